[design/stl_pkg.sv]
package stl_pkg;

    localparam int unsigned TOKEN_CAP_DEF = 1024;

    // Configuration port: one 32-bit register per word address.
    localparam int unsigned CFG_AW = 3;
    localparam logic [0:0] REG_IGNORE_COLONS = 1'b0;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_EOS  = 2'd2;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    localparam int unsigned MAX_RES = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [9:0] len;
        logic       quoted;
        logic       last;
    } result_t;

    function automatic logic is_single(input logic [7:0] b, input logic ignore_colons);
        return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LPAREN) ||
               (b == CH_RPAREN) || (b == CH_SQUOTE) ||
               ((b == CH_COLON) && !ignore_colons);
    endfunction

    function automatic result_t mk_res(input logic [1:0] kind, input logic [7:0] data,
                                       input logic [9:0] len, input logic quoted);
        result_t r;
        r.kind   = kind;
        r.data   = data;
        r.len    = len;
        r.quoted = quoted;
        r.last   = 1'b0;
        return r;
    endfunction

endpackage

[design/script_token_lexer.sv]
// Latency: the first result of a byte is offered in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte causes at most one result and out_stall is
// low; a byte that causes k results (k up to 4) holds the input until its results drain,
// one result per cycle while out_stall is low. A byte with no result never stalls the input.
// Reset (rst_n low, asynchronous): lexer between tokens, token count zero,
// ignore_colons zero, result register empty.
module script_token_lexer #(
    parameter int unsigned TOKEN_CAP = stl_pkg::TOKEN_CAP_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                in_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                out_kind,
    output logic [7:0]                out_byte,
    output logic [9:0]                token_length,
    output logic                      was_quoted,
    output logic                      run_last,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [stl_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import stl_pkg::*;

    localparam int unsigned CW = $clog2(TOKEN_CAP);
    localparam logic [CW-1:0] CAP_M1 = CW'(TOKEN_CAP - 1);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_QUOTED,
        MODE_WORD
    } mode_t;

    mode_t         mode_reg, mode_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ignore_colons_reg;

    result_t       hold_reg [MAX_RES];
    result_t       res_next [MAX_RES];
    logic [2:0]    res_cnt;
    logic [2:0]    left_reg;
    logic [1:0]    idx_reg;

    logic          in_take;
    logic          out_take;
    logic          cfg_wr;
    logic          delim;

    assign delim = (in_byte <= CH_SPACE) || is_single(in_byte, ignore_colons_reg);

    // Next lexer state and the list of results for the byte on the input.
    always_comb
    begin
        logic [2:0] n;
        logic       do_word;
        logic       do_idle;
        n         = 3'd0;
        do_word   = 1'b0;
        do_idle   = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        for (int i = 0; i < MAX_RES; i++)
        begin
            res_next[i] = '0;
        end

        unique case (mode_reg)
            MODE_SLASH:
            begin
                if (in_byte == CH_SLASH)
                begin
                    mode_next = MODE_COMMENT;
                end
                else
                begin
                    // A lone slash starts a word; the byte is then lexed after it.
                    res_next[n[1:0]] = mk_res(KIND_BYTE, CH_SLASH, 10'd0, 1'b0);
                    n = n + 3'd1;
                    cnt_next = CW'(1);
                    if (cnt_next >= CAP_M1)
                    begin
                        res_next[n[1:0]] = mk_res(KIND_END, CH_NUL, 10'(cnt_next), 1'b0);
                        n = n + 3'd1;
                        mode_next = MODE_IDLE;
                        do_idle = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_WORD;
                        do_word = 1'b1;
                    end
                end
            end
            MODE_COMMENT:
            begin
                if (in_byte == CH_NUL)
                begin
                    res_next[n[1:0]] = mk_res(KIND_EOS, CH_NUL, 10'd0, 1'b0);
                    n = n + 3'd1;
                    mode_next = MODE_IDLE;
                end
                else if (in_byte == CH_NEWLINE)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_QUOTED:
            begin
                if (in_byte == CH_DQUOTE)
                begin
                    res_next[n[1:0]] = mk_res(KIND_END, CH_NUL, 10'(cnt_reg), 1'b1);
                    n = n + 3'd1;
                    mode_next = MODE_IDLE;
                end
                else if (in_byte == CH_NUL)
                begin
                    res_next[n[1:0]] = mk_res(KIND_END, CH_NUL, 10'(cnt_reg), 1'b1);
                    n = n + 3'd1;
                    res_next[n[1:0]] = mk_res(KIND_EOS, CH_NUL, 10'd0, 1'b0);
                    n = n + 3'd1;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    res_next[n[1:0]] = mk_res(KIND_BYTE, in_byte, 10'd0, 1'b0);
                    n = n + 3'd1;
                    cnt_next = cnt_reg + CW'(1);
                    if (cnt_next >= CAP_M1)
                    begin
                        res_next[n[1:0]] = mk_res(KIND_END, CH_NUL, 10'(cnt_next), 1'b1);
                        n = n + 3'd1;
                        mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_WORD:
            begin
                do_word = 1'b1;
            end
            default:
            begin
                do_idle = 1'b1;
            end
        endcase

        if (do_word)
        begin
            if (delim)
            begin
                res_next[n[1:0]] = mk_res(KIND_END, CH_NUL, 10'(cnt_next), 1'b0);
                n = n + 3'd1;
                mode_next = MODE_IDLE;
                do_idle = 1'b1;
            end
            else
            begin
                res_next[n[1:0]] = mk_res(KIND_BYTE, in_byte, 10'd0, 1'b0);
                n = n + 3'd1;
                cnt_next = cnt_next + CW'(1);
                if (cnt_next >= CAP_M1)
                begin
                    res_next[n[1:0]] = mk_res(KIND_END, CH_NUL, 10'(cnt_next), 1'b0);
                    n = n + 3'd1;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    mode_next = MODE_WORD;
                end
            end
        end

        if (do_idle)
        begin
            if (in_byte == CH_NUL)
            begin
                res_next[n[1:0]] = mk_res(KIND_EOS, CH_NUL, 10'd0, 1'b0);
                n = n + 3'd1;
                mode_next = MODE_IDLE;
            end
            else if (in_byte <= CH_SPACE)
            begin
                mode_next = MODE_IDLE;
            end
            else if (in_byte == CH_SLASH)
            begin
                mode_next = MODE_SLASH;
            end
            else if (in_byte == CH_DQUOTE)
            begin
                cnt_next = '0;
                mode_next = MODE_QUOTED;
            end
            else if (is_single(in_byte, ignore_colons_reg))
            begin
                res_next[n[1:0]] = mk_res(KIND_BYTE, in_byte, 10'd0, 1'b0);
                n = n + 3'd1;
                res_next[n[1:0]] = mk_res(KIND_END, CH_NUL, 10'd1, 1'b0);
                n = n + 3'd1;
                mode_next = MODE_IDLE;
            end
            else
            begin
                res_next[n[1:0]] = mk_res(KIND_BYTE, in_byte, 10'd0, 1'b0);
                n = n + 3'd1;
                cnt_next = CW'(1);
                if (cnt_next >= CAP_M1)
                begin
                    res_next[n[1:0]] = mk_res(KIND_END, CH_NUL, 10'(cnt_next), 1'b0);
                    n = n + 3'd1;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    mode_next = MODE_WORD;
                end
            end
        end

        if (n != 3'd0)
        begin
            res_next[2'(n - 3'd1)].last = 1'b1;
        end
        res_cnt = n;
    end

    // A new byte is taken once the result register is empty or its final entry leaves now.
    assign in_stall  = !((left_reg == 3'd0) || ((left_reg == 3'd1) && !out_stall));
    assign in_take   = in_valid && !in_stall;
    assign out_valid = (left_reg != 3'd0);
    assign out_take  = out_valid && !out_stall;

    assign out_kind     = hold_reg[idx_reg].kind;
    assign out_byte     = hold_reg[idx_reg].data;
    assign token_length = hold_reg[idx_reg].len;
    assign was_quoted   = hold_reg[idx_reg].quoted;
    assign run_last     = hold_reg[idx_reg].last;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_IGNORE_COLONS) ? {31'd0, ignore_colons_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDLE;
            cnt_reg           <= '0;
            ignore_colons_reg <= 1'b0;
            left_reg          <= 3'd0;
            idx_reg           <= 2'd0;
        end
        else
        begin
            if (cfg_wr && (paddr[2] == REG_IGNORE_COLONS))
            begin
                ignore_colons_reg <= pwdata[0];
            end
            if (in_take)
            begin
                mode_reg <= mode_next;
                cnt_reg  <= cnt_next;
                left_reg <= res_cnt;
                idx_reg  <= 2'd0;
            end
            else if (out_take)
            begin
                left_reg <= left_reg - 3'd1;
                idx_reg  <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                hold_reg[i] <= res_next[i];
            end
        end
    end

    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= 3'd4)
        else $error("result register holds more than four entries");

    a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_WORD) |-> ((cnt_reg != '0) && (cnt_reg < CAP_M1)))
        else $error("word open with a count outside its range");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (left_reg == 3'd1)) |-> run_last)
        else $error("final result of a byte lacks run_last");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_kind != KIND_BYTE)) |-> (out_byte == 8'd0))
        else $error("non-byte result carries a byte value");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (left_reg > 3'd1)) |-> 1'b0)
        else $error("byte accepted while earlier results are pending");

endmodule

[tb/sv/script_token_lexer_tb.sv]
`default_nettype none

module script_token_lexer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stl_pkg::*;

    localparam int unsigned CAP = TOKEN_CAP_DEF;
    localparam int QUIET_LIMIT = 3000;
    localparam logic [CFG_AW-1:0] COLON_ADDR = CFG_AW'(4 * int'(REG_IGNORE_COLONS));
    localparam logic [7:0] SOLO_CHARS [6] =
        '{CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_SQUOTE, CH_COLON};
    localparam logic [7:0] OPENING_TEXT [21] =
        '{CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_SQUOTE, CH_COLON,
          CH_SLASH, "x", CH_SPACE, CH_SLASH, CH_SLASH, "c", CH_NEWLINE,
          CH_DQUOTE, CH_DQUOTE, "a", CH_DQUOTE, 8'hFF, CH_DQUOTE, "q", CH_NUL};
    localparam logic [7:0] COLON_TEXT [11] =
        '{"a", CH_COLON, "b", CH_NUL, CH_SLASH, CH_SLASH, CH_NUL,
          CH_SLASH, CH_LBRACE, CH_SLASH, CH_NUL};

    typedef enum logic [2:0] {LX_IDLE, LX_SLASH, LX_COMMENT, LX_QUOTED, LX_WORD} lex_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] in_byte = 8'h00;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [9:0] token_length;
    logic was_quoted;
    logic run_last;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Predictor state.
    lex_mode_t lx_mode = LX_IDLE;
    int unsigned tok_len = 0;
    logic colon_plain = 1'b0;

    logic [7:0] text_q [$];
    result_t pending_results [$];

    int errors = 0;
    int bytes_taken = 0;
    int results_seen = 0;
    int cycle_cnt = 0;
    int quiet = 0;
    int in_gap = 0;
    int out_gap = 0;
    int in_odds = 2;
    int out_odds = 2;
    int hold_left = 0;
    logic held_once = 1'b0;
    logic calm = 1'b0;

    script_token_lexer #(.TOKEN_CAP(CAP)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_kind     (out_kind),
        .out_byte     (out_byte),
        .token_length (token_length),
        .was_quoted   (was_quoted),
        .run_last     (run_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 clk = ~clk;

    task automatic note_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    // ---------------------------------------------------------------- predictor

    function automatic logic solo_char(input logic [7:0] b);
        return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LPAREN) ||
               (b == CH_RPAREN) || (b == CH_SQUOTE) || (b == CH_COLON && !colon_plain);
    endfunction

    function automatic void expect_result(input logic [1:0] kind, input logic [7:0] b,
                                          input int unsigned len, input logic quoted);
        result_t r;
        r.kind   = kind;
        r.data   = b;
        r.len    = 10'(len);
        r.quoted = quoted;
        r.last   = 1'b0;
        pending_results.push_back(r);
    endfunction

    function automatic void word_append(input logic [7:0] b);
        expect_result(KIND_BYTE, b, 0, 1'b0);
        tok_len++;
        if (tok_len >= CAP - 1)
        begin
            expect_result(KIND_END, 8'h00, tok_len, 1'b0);
            lx_mode = LX_IDLE;
        end
        else
        begin
            lx_mode = LX_WORD;
        end
    endfunction

    function automatic void between_tokens(input logic [7:0] b);
        if (b == CH_NUL)
        begin
            expect_result(KIND_EOS, 8'h00, 0, 1'b0);
            lx_mode = LX_IDLE;
        end
        else if (b <= CH_SPACE)
        begin
            lx_mode = LX_IDLE;
        end
        else if (b == CH_SLASH)
        begin
            lx_mode = LX_SLASH;
        end
        else if (b == CH_DQUOTE)
        begin
            tok_len = 0;
            lx_mode = LX_QUOTED;
        end
        else if (solo_char(b))
        begin
            expect_result(KIND_BYTE, b, 0, 1'b0);
            expect_result(KIND_END, 8'h00, 1, 1'b0);
            lx_mode = LX_IDLE;
        end
        else
        begin
            tok_len = 0;
            word_append(b);
        end
    endfunction

    function automatic void in_word(input logic [7:0] b);
        if (b <= CH_SPACE || solo_char(b))
        begin
            expect_result(KIND_END, 8'h00, tok_len, 1'b0);
            lx_mode = LX_IDLE;
            between_tokens(b);
        end
        else
        begin
            word_append(b);
        end
    endfunction

    function automatic void lex_byte(input logic [7:0] b);
        int n_prior;
        n_prior = pending_results.size();
        case (lx_mode)
            LX_SLASH:
            begin
                if (b == CH_SLASH)
                begin
                    lx_mode = LX_COMMENT;
                end
                else
                begin
                    // The held slash opens a word, and the byte is lexed after it.
                    tok_len = 0;
                    word_append(CH_SLASH);
                    if (lx_mode == LX_WORD)
                        in_word(b);
                    else
                        between_tokens(b);
                end
            end
            LX_COMMENT:
            begin
                if (b == CH_NUL)
                begin
                    expect_result(KIND_EOS, 8'h00, 0, 1'b0);
                    lx_mode = LX_IDLE;
                end
                else if (b == CH_NEWLINE)
                begin
                    lx_mode = LX_IDLE;
                end
            end
            LX_QUOTED:
            begin
                if (b == CH_DQUOTE)
                begin
                    expect_result(KIND_END, 8'h00, tok_len, 1'b1);
                    lx_mode = LX_IDLE;
                end
                else if (b == CH_NUL)
                begin
                    expect_result(KIND_END, 8'h00, tok_len, 1'b1);
                    expect_result(KIND_EOS, 8'h00, 0, 1'b0);
                    lx_mode = LX_IDLE;
                end
                else
                begin
                    expect_result(KIND_BYTE, b, 0, 1'b0);
                    tok_len++;
                    if (tok_len >= CAP - 1)
                    begin
                        expect_result(KIND_END, 8'h00, tok_len, 1'b1);
                        lx_mode = LX_IDLE;
                    end
                end
            end
            LX_WORD:
            begin
                in_word(b);
            end
            default:
            begin
                between_tokens(b);
            end
        endcase
        if (pending_results.size() > n_prior)
            pending_results[pending_results.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void queue_phrase();
        int n;
        logic [7:0] b;
        case ($urandom_range(15, 0))
            0, 1, 2, 3:
            begin
                n = $urandom_range(9, 1);
                for (int i = 0; i < n; i++)
                begin
                    b = 8'($urandom_range(255, 33));
                    if (i == 0 && (b == CH_DQUOTE || b == CH_SLASH))
                        b = "_";
                    text_q.push_back(b);
                end
            end
            4, 5:
            begin
                text_q.push_back(CH_DQUOTE);
                n = $urandom_range(8, 0);
                for (int i = 0; i < n; i++)
                begin
                    b = 8'($urandom_range(255, 1));
                    text_q.push_back(b == CH_DQUOTE ? 8'h71 : b);
                end
                // Now and then the string is left open and runs on.
                if ($urandom_range(7, 0) != 0)
                    text_q.push_back(CH_DQUOTE);
            end
            6, 7:
            begin
                text_q.push_back(SOLO_CHARS[$urandom_range(5, 0)]);
            end
            8:
            begin
                text_q.push_back(CH_SLASH);
                text_q.push_back(CH_SLASH);
                n = $urandom_range(6, 0);
                for (int i = 0; i < n; i++)
                begin
                    b = 8'($urandom_range(255, 1));
                    text_q.push_back(b == CH_NEWLINE ? 8'h2D : b);
                end
                text_q.push_back($urandom_range(15, 0) == 0 ? CH_NUL : CH_NEWLINE);
            end
            9:
            begin
                text_q.push_back(CH_SLASH);
                text_q.push_back(8'($urandom_range(255, 0)));
            end
            10:
            begin
                text_q.push_back(CH_NUL);
            end
            11:
            begin
                n = $urandom_range(3, 1);
                for (int i = 0; i < n; i++)
                    text_q.push_back(8'($urandom_range(255, 0)));
            end
            default:
            begin
                n = $urandom_range(3, 1);
                for (int i = 0; i < n; i++)
                    text_q.push_back(8'($urandom_range(32, 1)));
            end
        endcase
    endfunction

    function automatic void queue_random(input int n);
        int target;
        target = text_q.size() + n;
        while (text_q.size() < target)
            queue_phrase();
    endfunction

    // A token of CAP - 1 to CAP + 1 bytes, so it reaches the cut; a quoted one is followed
    // by a quote, a z and a closing quote.
    function automatic void queue_long_token(input logic quoted);
        int n;
        n = CAP - 1 + $urandom_range(2, 0);
        if (quoted)
            text_q.push_back(CH_DQUOTE);
        for (int i = 0; i < n; i++)
            text_q.push_back(8'("a" + $urandom_range(25, 0)));
        if (quoted)
        begin
            text_q.push_back(CH_DQUOTE);
            text_q.push_back("z");
            text_q.push_back(CH_DQUOTE);
        end
        text_q.push_back(CH_SPACE);
    endfunction

    task automatic wait_drained();
        // Checked at the falling edge, once the driver and monitor have settled.
        while (text_q.size() != 0 || in_valid || pending_results.size() != 0)
            @(negedge clk);
        // Bytes that cause no result may still be in flight.
        repeat (6) @(posedge clk);
    endtask

    task automatic set_colon_mode(input logic v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COLON_ADDR;
        pwdata  <= {31'b0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        colon_plain = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[0] !== v)
            note_mismatch($sformatf("ignore_colons read back %0b, wrote %0b", prdata[0], v));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
            in_gap   <= 0;
        end
        else
        begin
            if (cycle_cnt % 256 == 0)
                in_odds <= $urandom_range(4, 0);
            if (in_valid && !in_stall)
            begin
                lex_byte(in_byte);
                bytes_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap != 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(15, 0) < in_odds)
                begin
                    in_gap   <= $urandom_range(13, 0);
                    in_valid <= 1'b0;
                end
                else if (text_q.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_byte  <= text_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic take_result();
        result_t want;
        if (pending_results.size() == 0)
        begin
            note_mismatch($sformatf("unexpected result kind %0d byte %02h len %0d",
                                    out_kind, out_byte, token_length));
        end
        else
        begin
            want = pending_results.pop_front();
            if (out_kind !== want.kind)
                note_mismatch($sformatf("out_kind %0d, expected %0d", out_kind, want.kind));
            if (out_byte !== want.data)
                note_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
            if (token_length !== want.len)
                note_mismatch($sformatf("token_length %0d, expected %0d",
                                        token_length, want.len));
            if (was_quoted !== want.quoted)
                note_mismatch($sformatf("was_quoted %0b, expected %0b",
                                        was_quoted, want.quoted));
            if (run_last !== want.last)
                note_mismatch($sformatf("run_last %0b, expected %0b", run_last, want.last));
        end
        results_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap   <= 0;
            hold_left <= 0;
        end
        else
        begin
            if (cycle_cnt % 256 == 128)
                out_odds <= $urandom_range(4, 0);
            if (out_valid && !out_stall)
                take_result();
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (!held_once && results_seen >= 150)
            begin
                // Long back-pressure so the block fills up and stalls its input.
                held_once <= 1'b1;
                hold_left <= 90;
                out_stall <= 1'b1;
            end
            else if (out_gap != 0)
            begin
                out_gap   <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(15, 0) < out_odds)
            begin
                out_gap   <= $urandom_range(13, 0);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet <= 0;
        end
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        set_colon_mode(1'b0);
        @(negedge clk);
        foreach (OPENING_TEXT[i])
            text_q.push_back(OPENING_TEXT[i]);
        wait_drained();

        set_colon_mode(1'b1);
        @(negedge clk);
        foreach (COLON_TEXT[i])
            text_q.push_back(COLON_TEXT[i]);
        queue_random(160);
        wait_drained();

        set_colon_mode(1'b0);
        @(negedge clk);
        queue_random(60);
        queue_long_token(1'b0);
        queue_random(40);
        queue_long_token(1'b1);
        queue_random(60);
        wait_drained();

        set_colon_mode(1'b1);
        @(negedge clk);
        queue_random(100);
        while (text_q.size() != 0)
            @(posedge clk);
        // The closing stretch runs without idling on either side.
        calm <= 1'b1;
        @(negedge clk);
        queue_random(60);
        wait_drained();

        if (pending_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        $display("Run covered %0d bytes and %0d results in both colon modes,", bytes_taken,
                 results_seen);
        $display("with words and quoted strings cut at the %0d-byte token cap.", CAP - 1);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

[script_token_lexer.f]
design/stl_pkg.sv
design/script_token_lexer.sv
tb/sv/script_token_lexer_tb.sv
